// ===== rtl/core/fmrc_pkg.sv =====
// shared types, constants and helpers of the first-match rule classifier
`timescale 1ns / 1ps

package fmrc_pkg;

  localparam int RULES        = 16;
  localparam int PREFIX_BYTES = 8;

  localparam int CNT_W  = $clog2(RULES + 1);
  localparam int IDX_W  = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int PLEN_W = $clog2(PREFIX_BYTES + 1);

  localparam int IN_DATA_W  = 336;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_CLASSIFY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic [63:0] service_high;
    logic [63:0] service_low;
    logic [63:0] char_high;
    logic [63:0] char_low;
    logic [63:0] data_bytes;
    logic [7:0]  data_len;
  } query_t;

  typedef struct packed {
    logic [63:0]       service_high;
    logic [63:0]       service_low;
    logic [63:0]       char_high;
    logic [63:0]       char_low;
    logic [63:0]       prefix;
    logic [PLEN_W-1:0] prefix_len;
    logic [7:0]        event_id;
  } rule_t;

  typedef struct packed {
    logic       found;
    logic [7:0] event_id;
  } hit_t;

  function automatic logic [63:0] byte_mask(input logic [7:0] nbytes);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (nbytes > 8'(b)) begin
        m[8*b +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/fmrc_cell.sv =====
// one rule cell: holds a rule, compares it to the query, passes the first hit on
`timescale 1ns / 1ps

module fmrc_cell (
  input  logic           clk_i,
  input  logic           wr_en_i,
  input  fmrc_pkg::rule_t wr_rule_i,
  input  logic           live_i,
  input  fmrc_pkg::query_t query_i,
  input  fmrc_pkg::hit_t  hit_i,
  output fmrc_pkg::hit_t  hit_o
);
  import fmrc_pkg::*;

  rule_t       rule_q;
  hit_t        hit_d;
  hit_t        hit_q;
  logic        ids_eq;
  logic        len_ok;
  logic        prefix_eq;
  logic [63:0] mask;

  always_comb begin
    mask      = byte_mask(8'(rule_q.prefix_len));
    ids_eq    = (rule_q.service_high == query_i.service_high) &&
                (rule_q.service_low == query_i.service_low) &&
                (rule_q.char_high == query_i.char_high) &&
                (rule_q.char_low == query_i.char_low);
    len_ok    = query_i.data_len >= 8'(rule_q.prefix_len);
    prefix_eq = (query_i.data_bytes & mask) == rule_q.prefix;
    // earlier cells have priority
    if (hit_i.found) begin
      hit_d = hit_i;
    end else if (live_i && ids_eq && len_ok && prefix_eq) begin
      hit_d.found    = 1'b1;
      hit_d.event_id = rule_q.event_id;
    end else begin
      hit_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rule_q <= wr_rule_i;
    end
    hit_q <= hit_d;
  end

  assign hit_o = hit_q;

endmodule

// ===== rtl/core/first_match_rule_classifier.sv =====
// top level of the first-match rule classifier
`timescale 1ns / 1ps

// Input channel s_axis: tuser carries the operation (add rule, clear table,
// classify write), tdata the ids, payload bytes, length and event id.
// Output channel m_axis: one transfer per input transfer, in order; tuser is
// the matched flag, tdata the event and the status code.
// Rules live in a row of RULES cells. A classify holds the query steady while
// the hit result moves one cell per cycle, so the first matching rule wins.
// A classify gives its result once the hit has passed the whole cell row; an
// add, a clear or an unused code gives its result without that wait. One item
// is in work at a time; the next input transfer is taken as soon as the result
// is in the output register, even while the receiver stalls it.
// A stalled result holds on m_axis until taken; if a second result is ready
// behind it, the input side waits.
// Reset empties the table and drops any item in work; rule contents are not
// cleared, only the rule count.
module first_match_rule_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // service_high, service_low, char_high, char_low, data_bytes, data_len,
  // event_id
  input  logic [fmrc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // op
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // event_out, status, zero fill
  output logic [fmrc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // matched
  output logic                               m_axis_tuser
);
  import fmrc_pkg::*;

  logic              in_xfer;
  op_e               in_op;
  query_t            in_query;
  logic [7:0]        in_event;
  logic              add_ok;
  status_e           add_status;
  rule_t             wr_rule;
  logic [RULES-1:0]  wr_en;
  logic [RULES-1:0]  live;
  hit_t              hit [RULES+1];
  logic              slot_free;
  logic              done;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  timer_q, timer_d;
  logic              classify_q, classify_d;
  status_e           status_q, status_d;
  query_t            query_q;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_event_q, out_event_d;
  logic              out_matched_q, out_matched_d;
  status_e           out_status_q, out_status_d;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign in_op    = op_e'(s_axis_tuser);
  assign in_query = query_t'({s_axis_tdata[63:0], s_axis_tdata[127:64],
                              s_axis_tdata[191:128], s_axis_tdata[255:192],
                              s_axis_tdata[319:256], s_axis_tdata[327:320]});
  assign in_event = s_axis_tdata[335:328];

  assign s_axis_tready = !busy_q;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign done          = busy_q && (timer_q == '0) && slot_free;

  always_comb begin
    add_ok     = 1'b0;
    add_status = ST_OK;
    if (count_q >= CNT_W'(RULES)) begin
      add_status = ST_FULL;
    end else if (in_query.data_len > 8'(PREFIX_BYTES)) begin
      add_status = ST_TOO_LONG;
    end else begin
      add_ok = in_xfer && (in_op == OP_ADD);
    end
  end

  always_comb begin
    wr_rule.service_high = in_query.service_high;
    wr_rule.service_low  = in_query.service_low;
    wr_rule.char_high    = in_query.char_high;
    wr_rule.char_low     = in_query.char_low;
    wr_rule.prefix       = in_query.data_bytes & byte_mask(in_query.data_len);
    wr_rule.prefix_len   = in_query.data_len[PLEN_W-1:0];
    wr_rule.event_id     = in_event;
  end

  assign hit[0] = '0;

  for (genvar i = 0; i < RULES; i++) begin : g_cell
    assign wr_en[i] = add_ok && (count_q[IDX_W-1:0] == IDX_W'(i));
    assign live[i]  = CNT_W'(i) < count_q;

    fmrc_cell u_cell (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en[i]),
      .wr_rule_i (wr_rule),
      .live_i    (live[i]),
      .query_i   (query_q),
      .hit_i     (hit[i]),
      .hit_o     (hit[i+1])
    );
  end

  always_comb begin
    count_d       = count_q;
    busy_d        = busy_q;
    timer_d       = timer_q;
    classify_d    = classify_q;
    status_d      = status_q;
    out_valid_d   = out_valid_q;
    out_event_d   = out_event_q;
    out_matched_d = out_matched_q;
    out_status_d  = out_status_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (busy_q && (timer_q != '0)) begin
      timer_d = timer_q - 1'b1;
    end

    if (done) begin
      busy_d        = 1'b0;
      out_valid_d   = 1'b1;
      out_matched_d = classify_q && hit[RULES].found;
      out_event_d   = (classify_q && hit[RULES].found) ? hit[RULES].event_id : 8'd0;
      out_status_d  = status_q;
    end

    if (in_xfer) begin
      busy_d     = 1'b1;
      timer_d    = '0;
      classify_d = 1'b0;
      status_d   = ST_OK;
      unique case (in_op)
        OP_ADD: begin
          status_d = add_status;
          if (add_ok) begin
            count_d = count_q + 1'b1;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        OP_CLASSIFY: begin
          classify_d = 1'b1;
          timer_d    = CNT_W'(RULES);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    classify_q    <= classify_d;
    status_q      <= status_d;
    out_event_q   <= out_event_d;
    out_matched_q <= out_matched_d;
    out_status_q  <= out_status_d;
    if (in_xfer) begin
      query_q <= in_query;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_status_q, out_event_q};
  assign m_axis_tuser  = out_matched_q;

endmodule
